// File: sv/krs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krs_pkg
// Shared constants, operation codes and types of the keyed record slot table.
// ----------------------------------------------------------------------------
package krs_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int HELD_W     = 6;
  localparam int KIND_W     = 3;

  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REWIND = 3'd5;

  typedef struct packed {
    logic [7:0]  key;
    logic [7:0]  flags;
    logic [11:0] start;
    logic [11:0] stop;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // One beat of the slot scan: read data for slot idx is valid this cycle,
  // or the scan has finished.
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] idx;
    logic              fin;
  } beat_t;

endpackage

// File: sv/krs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krs_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module krs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                             wdata,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: sv/krs_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krs_scan
// Slot scan engine: walks slot addresses from a start position to the end of
// the table, one read per cycle, and marks when each read word returns.
// ----------------------------------------------------------------------------
module krs_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [krs_pkg::CNT_W-1:0]  from_pos,
  output logic                       rd_en,
  output logic [krs_pkg::ADDR_W-1:0] rd_addr,
  output krs_pkg::beat_t             beat
);

  logic                      active;
  logic [krs_pkg::CNT_W-1:0] cnt;
  logic                      in_range;

  assign in_range = cnt < krs_pkg::CNT_W'(krs_pkg::SLOT_COUNT);
  assign rd_en    = active && in_range;
  assign rd_addr  = cnt[krs_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      beat.vld <= 1'b0;
      beat.fin <= 1'b0;
    end else begin
      beat.vld <= 1'b0;
      beat.fin <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= from_pos;
      end else if (active) begin
        if (in_range) begin
          cnt      <= cnt + 1'b1;
          beat.vld <= 1'b1;
          beat.idx <= cnt[krs_pkg::ADDR_W-1:0];
        end else begin
          // The last read word has been seen by now, so the finish follows it.
          active   <= 1'b0;
          beat.fin <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/keyed_record_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_slot_table
// Table of keyed records held in one single-port RAM, with add, delete,
// update, get and an ordered walk over the occupied slots.
// ----------------------------------------------------------------------------
//  Channel    Signals                                        Handshake
//  command    kind, key, flag_bits, start_time, stop_time    start & !busy
//  result     ok, rec_key, rec_flags, rec_start, rec_stop,   done (one cycle)
//             entries_held, more_left
//
// Every command scans the RAM from its start slot to the end of the table,
// one slot a cycle: add, delete, update and get start at slot 0, next at the
// walk position, rewind at the end (no slot read). The single RAM port serves
// the scan reads and the final write. The result is shown for one cycle with
// done; busy drops in that same cycle. Reset is synchronous and empties the
// table at once through per-slot valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_record_slot_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [7:0]  key,
  input  logic [7:0]  flag_bits,
  input  logic [11:0] start_time,
  input  logic [11:0] stop_time,
  output logic        done,
  output logic        ok,
  output logic [7:0]  rec_key,
  output logic [7:0]  rec_flags,
  output logic [11:0] rec_start,
  output logic [11:0] rec_stop,
  output logic [5:0]  entries_held,
  output logic        more_left
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  localparam logic [krs_pkg::CNT_W-1:0] END_POS = krs_pkg::CNT_W'(krs_pkg::SLOT_COUNT);

  logic state;

  logic [krs_pkg::KIND_W-1:0] kind_r;
  logic [7:0]                 key_r;
  logic [7:0]                 flags_r;
  logic [11:0]                start_r;
  logic [11:0]                stop_r;

  logic [krs_pkg::SLOT_COUNT-1:0] valid;
  logic [krs_pkg::CNT_W-1:0]      entry_count;
  logic [krs_pkg::CNT_W-1:0]      walk_pos;
  logic [krs_pkg::CNT_W-1:0]      walk_visited;

  logic                       hit;
  logic [krs_pkg::ADDR_W-1:0] hit_idx;
  krs_pkg::rec_t              hit_rec;
  logic                       empty_hit;
  logic [krs_pkg::ADDR_W-1:0] empty_idx;

  logic                       go;
  logic [krs_pkg::CNT_W-1:0]  from_pos;
  logic                       rd_en;
  logic [krs_pkg::ADDR_W-1:0] rd_addr;
  krs_pkg::beat_t             beat;
  logic                       vbit_q;
  logic [krs_pkg::REC_W-1:0]  rdata;
  krs_pkg::rec_t              rd_rec;
  logic                       match;

  logic                       finish;
  logic                       we;
  logic [krs_pkg::ADDR_W-1:0] waddr;
  krs_pkg::rec_t              wrec;
  logic [krs_pkg::ADDR_W-1:0] ram_addr;

  logic                      ok_next;
  krs_pkg::rec_t             rec_next;
  logic [krs_pkg::CNT_W-1:0] count_next;
  logic [krs_pkg::CNT_W-1:0] pos_next;
  logic [krs_pkg::CNT_W-1:0] visited_next;
  logic                      set_valid;
  logic                      clr_valid;

  assign busy   = (state == ST_SCAN);
  assign go     = start && (state == ST_IDLE);
  assign finish = (state == ST_SCAN) && beat.fin;

  always_comb begin
    case (kind)
      krs_pkg::KIND_ADD,
      krs_pkg::KIND_DELETE,
      krs_pkg::KIND_UPDATE,
      krs_pkg::KIND_GET:  from_pos = '0;
      krs_pkg::KIND_NEXT: from_pos = walk_pos;
      default:            from_pos = END_POS;
    endcase
  end

  krs_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .from_pos (from_pos),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .beat     (beat)
  );

  assign ram_addr = we ? waddr : rd_addr;

  krs_ram #(
    .WIDTH (krs_pkg::REC_W),
    .DEPTH (krs_pkg::SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .re    (rd_en),
    .addr  (ram_addr),
    .wdata (wrec),
    .rdata (rdata)
  );

  // A slot never written since reset reads as an empty record.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      vbit_q <= valid[rd_addr];
    end
  end

  assign rd_rec = vbit_q ? krs_pkg::rec_t'(rdata) : '0;

  always_comb begin
    if (kind_r == krs_pkg::KIND_NEXT) begin
      match = (rd_rec.key != 8'd0);
    end else begin
      match = (key_r != 8'd0) && (rd_rec.key == key_r);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hit       <= 1'b0;
      empty_hit <= 1'b0;
    end else if (beat.vld) begin
      if (match && !hit) begin
        hit     <= 1'b1;
        hit_idx <= beat.idx;
        hit_rec <= rd_rec;
      end
      if ((rd_rec.key == 8'd0) && !empty_hit) begin
        empty_hit <= 1'b1;
        empty_idx <= beat.idx;
      end
    end
  end

  always_comb begin
    ok_next      = 1'b0;
    rec_next     = '0;
    count_next   = entry_count;
    pos_next     = walk_pos;
    visited_next = walk_visited;
    we           = 1'b0;
    waddr        = hit_idx;
    wrec         = '{key: key_r, flags: flags_r, start: start_r, stop: stop_r};
    set_valid    = 1'b0;
    clr_valid    = 1'b0;
    case (kind_r)
      krs_pkg::KIND_ADD: begin
        if ((key_r != 8'd0) && !hit && empty_hit) begin
          ok_next    = 1'b1;
          count_next = entry_count + 1'b1;
          we         = finish;
          waddr      = empty_idx;
          set_valid  = 1'b1;
        end
      end
      krs_pkg::KIND_DELETE: begin
        if (hit) begin
          ok_next   = 1'b1;
          clr_valid = 1'b1;
          if (entry_count != '0) begin
            count_next = entry_count - 1'b1;
          end
        end
      end
      krs_pkg::KIND_UPDATE: begin
        if (hit) begin
          ok_next = 1'b1;
          we      = finish;
        end
      end
      krs_pkg::KIND_GET: begin
        if (hit) begin
          ok_next  = 1'b1;
          rec_next = hit_rec;
        end
      end
      krs_pkg::KIND_NEXT: begin
        // The walk skips empty slots even when nothing is returned.
        pos_next = hit ? krs_pkg::CNT_W'(hit_idx) : END_POS;
        if (hit && (walk_visited < entry_count)) begin
          ok_next      = 1'b1;
          rec_next     = hit_rec;
          pos_next     = krs_pkg::CNT_W'(hit_idx) + 1'b1;
          visited_next = walk_visited + 1'b1;
        end
      end
      krs_pkg::KIND_REWIND: begin
        ok_next      = 1'b1;
        pos_next     = '0;
        visited_next = '0;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (go) begin
      kind_r  <= kind;
      key_r   <= key;
      flags_r <= flag_bits;
      start_r <= start_time;
      stop_r  <= stop_time;
    end
    if (finish) begin
      ok           <= ok_next;
      rec_key      <= rec_next.key;
      rec_flags    <= rec_next.flags;
      rec_start    <= rec_next.start;
      rec_stop     <= rec_next.stop;
      entries_held <= krs_pkg::HELD_W'(count_next);
      more_left    <= (visited_next < count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done         <= 1'b0;
      valid        <= '0;
      entry_count  <= '0;
      walk_pos     <= '0;
      walk_visited <= '0;
    end else begin
      done <= finish;
      case (state)
        ST_IDLE: begin
          if (go) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (beat.fin) begin
            state        <= ST_IDLE;
            entry_count  <= count_next;
            walk_pos     <= pos_next;
            walk_visited <= visited_next;
            if (set_valid) begin
              valid[empty_idx] <= 1'b1;
            end
            if (clr_valid) begin
              valid[hit_idx] <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
